// ----- src/nns_pkg.sv -----
// Shared constants and types for the nearest-neighbor scaler with gray output.
// No dependencies.
package nns_pkg;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;
  localparam int COORD_W   = 8;
  localparam int PIX_W     = 8;
  localparam int RGB_W     = 3 * PIX_W;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // gray = (11*B + 59*G + 30*R) / 100, divide done as multiply by 2^22/100 rounded up
  localparam int SUM_W      = 15;
  localparam int RECIP_W    = 16;
  localparam int GRAY_SHIFT = 22;
  localparam int PROD_W     = SUM_W + RECIP_W;
  localparam logic [SUM_W-1:0]   GRAY_K_B   = SUM_W'(11);
  localparam logic [SUM_W-1:0]   GRAY_K_G   = SUM_W'(59);
  localparam logic [SUM_W-1:0]   GRAY_K_R   = SUM_W'(30);
  localparam logic [RECIP_W-1:0] GRAY_RECIP = RECIP_W'(41944);

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_OUT_WIDTH  = 3'd2,
    CFG_OUT_HEIGHT = 3'd3,
    CFG_GRAY_EN    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic valid;
    logic err;
  } pix_ctl_t;

endpackage

// ----- src/nns_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Divisor must stay stable while words are in flight. No package dependency.
module nns_div #(
  parameter int NW = 17,
  parameter int DW = 9,
  parameter int QW = 9
) (
  input  logic          clk,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int XW = DW + QW;

  logic [XW-1:0] rem_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [XW-1:0] rem_in [QW];
  logic [QW-1:0] quo_in [QW];
  logic [XW-1:0] rem_nxt [QW];
  logic [QW-1:0] quo_nxt [QW];
  logic [XW-1:0] dsh [QW];

  always_comb begin
    rem_in[0] = XW'(num_i);
    quo_in[0] = '0;
    for (int s = 1; s < QW; s++) begin
      rem_in[s] = rem_r[s-1];
      quo_in[s] = quo_r[s-1];
    end
    for (int s = 0; s < QW; s++) begin
      dsh[s] = XW'(den_i) << (QW - 1 - s);
      if (rem_in[s] >= dsh[s]) begin
        rem_nxt[s] = rem_in[s] - dsh[s];
        quo_nxt[s] = quo_in[s] | (QW'(1) << (QW - 1 - s));
      end else begin
        rem_nxt[s] = rem_in[s];
        quo_nxt[s] = quo_in[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QW; s++) begin
      rem_r[s] <= rem_nxt[s];
      quo_r[s] <= quo_nxt[s];
    end
  end

  assign quo_o = quo_r[QW-1];

endmodule

// ----- src/nns_frame_mem.sv -----
// Source frame store: one write or one read per cycle, registered read data.
// Uses nns_pkg for the pixel width.
module nns_frame_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             addr,
  input  logic [nns_pkg::RGB_W-1:0] wdata,
  output logic [nns_pkg::RGB_W-1:0] rdata
);
  import nns_pkg::*;

  logic [RGB_W-1:0] mem [DEPTH];
  logic [RGB_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/nns_gray.sv -----
// Gray conversion and output register stages g1, g2 and o.
// Uses nns_pkg for coefficients and the control struct.
module nns_gray (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      gray_en,
  input  nns_pkg::pix_ctl_t         in_ctl,
  input  logic [nns_pkg::RGB_W-1:0] in_pix,
  output nns_pkg::pix_ctl_t         out_ctl,
  output logic [nns_pkg::PIX_W-1:0] out_blue,
  output logic [nns_pkg::PIX_W-1:0] out_green,
  output logic [nns_pkg::PIX_W-1:0] out_red
);
  import nns_pkg::*;

  pix_ctl_t          g1_ctl_r, g2_ctl_r, o_ctl_r;
  logic [RGB_W-1:0]  g1_pix_r, g2_pix_r;
  logic [SUM_W-1:0]  g1_sum_r;
  logic [PROD_W-1:0] g2_prod_r;
  logic [PIX_W-1:0]  o_blue_r, o_green_r, o_red_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [PIX_W-1:0]  gray;

  assign sum_nxt = SUM_W'(in_pix[PIX_W-1:0]) * GRAY_K_B
                 + SUM_W'(in_pix[2*PIX_W-1:PIX_W]) * GRAY_K_G
                 + SUM_W'(in_pix[3*PIX_W-1:2*PIX_W]) * GRAY_K_R;

  assign gray = g2_prod_r[GRAY_SHIFT +: PIX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_ctl_r <= '0;
      g2_ctl_r <= '0;
      o_ctl_r  <= '0;
    end else begin
      g1_ctl_r <= in_ctl;
      g2_ctl_r <= g1_ctl_r;
      o_ctl_r  <= g2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    g1_pix_r  <= in_pix;
    g1_sum_r  <= sum_nxt;
    g2_pix_r  <= g1_pix_r;
    g2_prod_r <= PROD_W'(g1_sum_r) * PROD_W'(GRAY_RECIP);
    if (g2_ctl_r.err) begin
      o_blue_r  <= '0;
      o_green_r <= '0;
      o_red_r   <= '0;
    end else if (gray_en) begin
      o_blue_r  <= gray;
      o_green_r <= gray;
      o_red_r   <= gray;
    end else begin
      o_blue_r  <= g2_pix_r[PIX_W-1:0];
      o_green_r <= g2_pix_r[2*PIX_W-1:PIX_W];
      o_red_r   <= g2_pix_r[3*PIX_W-1:2*PIX_W];
    end
  end

  assign out_ctl   = o_ctl_r;
  assign out_blue  = o_blue_r;
  assign out_green = o_green_r;
  assign out_red   = o_red_r;

endmodule

// ----- src/nearest_neighbor_scaler_gray_unit.sv -----
// Nearest-neighbor scaler with gray option, top level. Uses nns_pkg, nns_div,
// nns_frame_mem and nns_gray.
// Throughput: one word per clock, busy is never raised.
// A fetch result is strobed on out_valid after stage 1, the 9-stage coordinate dividers,
// the address stage, the frame store read and the gray stages.
// Reset (synchronous, rst_n low) clears the pipeline and config; frame store is not cleared.
module nearest_neighbor_scaler_gray_unit #(
  parameter int MAX_WIDTH  = nns_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = nns_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [nns_pkg::COORD_W-1:0]   in_row,
  input  logic [nns_pkg::COORD_W-1:0]   in_col,
  input  logic [nns_pkg::PIX_W-1:0]     in_blue_in,
  input  logic [nns_pkg::PIX_W-1:0]     in_green_in,
  input  logic [nns_pkg::PIX_W-1:0]     in_red_in,
  output logic                          out_valid,
  output logic [nns_pkg::PIX_W-1:0]     out_blue_out,
  output logic [nns_pkg::PIX_W-1:0]     out_green_out,
  output logic [nns_pkg::PIX_W-1:0]     out_red_out,
  output logic                          out_range_error,
  input  logic                          cfg_we,
  input  logic [nns_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nns_pkg::CFG_W-1:0]     cfg_data
);
  import nns_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = COORD_W + CFG_W;
  localparam int QW    = CFG_W;
  localparam logic [AW-1:0] WSTRIDE = AW'(MAX_WIDTH);

  typedef struct packed {
    logic             fetch;
    logic             err;
    logic [AW-1:0]    ld_addr;
    logic [RGB_W-1:0] pix;
  } side_t;

  logic [CFG_W-1:0] src_width_r, src_height_r, out_width_r, out_height_r;
  logic             gray_en_r;

  logic             accept;
  logic             load_ok;
  logic [CFG_W-1:0] sw_clamp, sh_clamp;

  logic             s1_valid_r;
  side_t            s1_side_r;
  logic [NW-1:0]    s1_num_row_r, s1_num_col_r;

  logic             dv_valid_r [QW];
  side_t            dv_side_r  [QW];
  logic [QW-1:0]    src_row, src_col;

  logic             a_valid_r, a_we_r, a_err_r;
  logic [AW-1:0]    a_addr_r;
  logic [RGB_W-1:0] a_pix_r;
  logic [AW-1:0]    addr_nxt;

  pix_ctl_t         m_ctl_r;
  logic [RGB_W-1:0] m_rdata;
  pix_ctl_t         o_ctl;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= DIM_RESET;
      src_height_r <= DIM_RESET;
      out_width_r  <= DIM_RESET;
      out_height_r <= DIM_RESET;
      gray_en_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_data;
        CFG_SRC_HEIGHT: src_height_r <= cfg_data;
        CFG_OUT_WIDTH:  out_width_r  <= cfg_data;
        CFG_OUT_HEIGHT: out_height_r <= cfg_data;
        CFG_GRAY_EN:    gray_en_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (src_width_r == '0) begin
      sw_clamp = CFG_W'(1);
    end else if (int'(src_width_r) > MAX_WIDTH) begin
      sw_clamp = CFG_W'(MAX_WIDTH);
    end else begin
      sw_clamp = src_width_r;
    end
    if (src_height_r == '0) begin
      sh_clamp = CFG_W'(1);
    end else if (int'(src_height_r) > MAX_HEIGHT) begin
      sh_clamp = CFG_W'(MAX_HEIGHT);
    end else begin
      sh_clamp = src_height_r;
    end
  end

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign load_ok = (CFG_W'(in_row) < src_height_r) && (int'(in_row) < MAX_HEIGHT) &&
                   (CFG_W'(in_col) < src_width_r) && (int'(in_col) < MAX_WIDTH);

  // stage 1: range checks and scale products; rejected loads drop here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept && (in_mode || load_ok);
    end
  end

  always_ff @(posedge clk) begin
    s1_side_r.fetch   <= in_mode;
    s1_side_r.err     <= (CFG_W'(in_row) >= out_height_r) || (CFG_W'(in_col) >= out_width_r);
    s1_side_r.ld_addr <= AW'(in_row) * WSTRIDE + AW'(in_col);
    s1_side_r.pix     <= {in_red_in, in_green_in, in_blue_in};
    s1_num_row_r      <= NW'(in_row) * NW'(sh_clamp);
    s1_num_col_r      <= NW'(in_col) * NW'(sw_clamp);
  end

  // coordinate dividers with matching side pipeline
  nns_div #(.NW(NW), .DW(CFG_W), .QW(QW)) u_div_row (
    .clk   (clk),
    .num_i (s1_num_row_r),
    .den_i (out_height_r),
    .quo_o (src_row)
  );

  nns_div #(.NW(NW), .DW(CFG_W), .QW(QW)) u_div_col (
    .clk   (clk),
    .num_i (s1_num_col_r),
    .den_i (out_width_r),
    .quo_o (src_col)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QW; i++) begin
        dv_valid_r[i] <= 1'b0;
      end
    end else begin
      dv_valid_r[0] <= s1_valid_r;
      for (int i = 1; i < QW; i++) begin
        dv_valid_r[i] <= dv_valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dv_side_r[0] <= s1_side_r;
    for (int i = 1; i < QW; i++) begin
      dv_side_r[i] <= dv_side_r[i-1];
    end
  end

  // address stage: loads and fetches share one store port in word order
  assign addr_nxt = dv_side_r[QW-1].fetch ? (AW'(src_row) * WSTRIDE + AW'(src_col))
                                          : dv_side_r[QW-1].ld_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_we_r    <= 1'b0;
    end else begin
      a_valid_r <= dv_valid_r[QW-1];
      a_we_r    <= dv_valid_r[QW-1] && !dv_side_r[QW-1].fetch;
    end
  end

  always_ff @(posedge clk) begin
    a_addr_r <= addr_nxt;
    a_pix_r  <= dv_side_r[QW-1].pix;
    a_err_r  <= dv_side_r[QW-1].err;
  end

  nns_frame_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (a_we_r),
    .addr  (a_addr_r),
    .wdata (a_pix_r),
    .rdata (m_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_ctl_r.valid <= 1'b0;
    end else begin
      m_ctl_r.valid <= a_valid_r && !a_we_r;
    end
    m_ctl_r.err <= a_err_r;
  end

  nns_gray u_gray (
    .clk       (clk),
    .rst_n     (rst_n),
    .gray_en   (gray_en_r),
    .in_ctl    (m_ctl_r),
    .in_pix    (m_rdata),
    .out_ctl   (o_ctl),
    .out_blue  (out_blue_out),
    .out_green (out_green_out),
    .out_red   (out_red_out)
  );

  assign out_valid       = o_ctl.valid;
  assign out_range_error = o_ctl.err;

`ifndef SYNTHESIS
  a_fetch_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode) |-> ##15 out_valid)
    else $error("fetch word produced no result");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_side_r.fetch) |-> ##14 !out_valid)
    else $error("load word produced a result");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |->
      (out_blue_out == '0 && out_green_out == '0 && out_red_out == '0))
    else $error("range error with nonzero pixel");

  a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_range_error && $past(gray_en_r)) |->
      (out_blue_out == out_green_out && out_green_out == out_red_out))
    else $error("gray channels differ");
`endif

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for nearest_neighbor_scaler_gray_unit: directed table, then random
// load/fetch phases under changing frame sizes, checked against an in-bench pixel predictor.
// Depends on nns_pkg and the scaler RTL.
`timescale 1ns / 1ps

module testbench;
  import nns_pkg::*;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
  localparam int STORE_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int PIPE_DRAIN  = 20;
  localparam int IDLE_LIMIT  = 2000;
  localparam int WORD_TARGET = 1700;
  localparam int N_PHASES    = 12;
  localparam int SHOW_ERRORS = 10;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   blue;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   red;
  } word_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             err;
  } pixel_t;

  typedef enum logic { ROW_WORD, ROW_CFG } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    word_t                w;
    pixel_t               want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_mode;
  logic [COORD_W-1:0]   in_row;
  logic [COORD_W-1:0]   in_col;
  logic [PIX_W-1:0]     in_blue_in;
  logic [PIX_W-1:0]     in_green_in;
  logic [PIX_W-1:0]     in_red_in;
  logic                 out_valid;
  logic [PIX_W-1:0]     out_blue_out;
  logic [PIX_W-1:0]     out_green_out;
  logic [PIX_W-1:0]     out_red_out;
  logic                 out_range_error;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // predictor copy of the block
  logic [RGB_W-1:0] frame_copy [STORE_DEPTH];
  bit               written [STORE_DEPTH];
  logic [CFG_W-1:0] src_w, src_h, out_w, out_h;
  logic             gray_on;

  pixel_t   pixel_q [$];
  dir_row_t dir_rows [$];
  int       errors = 0;
  int       idle_cycles = 0;
  int       burst_left = 0;

  nearest_neighbor_scaler_gray_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_blue_in      (in_blue_in),
    .in_green_in     (in_green_in),
    .in_red_in       (in_red_in),
    .out_valid       (out_valid),
    .out_blue_out    (out_blue_out),
    .out_green_out   (out_green_out),
    .out_red_out     (out_red_out),
    .out_range_error (out_range_error),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_dim(logic [CFG_W-1:0] v, int hi);
    if (v == '0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic int dim_top(logic [CFG_W-1:0] v);
    return (int'(v) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : int'(v) - 1;
  endfunction

  function automatic bit load_lands(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
    return (CFG_W'(row) < src_h) && (CFG_W'(col) < src_w);
  endfunction

  function automatic bit fetch_in_range(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
    return (CFG_W'(row) < out_h) && (CFG_W'(col) < out_w);
  endfunction

  // store address of the nearest source pixel; caller guarantees the fetch is in range
  function automatic int src_index(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
    int sh, sw, sr, sc;
    sh = clamp_dim(src_h, MAX_HEIGHT_DEF);
    sw = clamp_dim(src_w, MAX_WIDTH_DEF);
    sr = (int'(row) * sh) / int'(out_h);
    sc = (int'(col) * sw) / int'(out_w);
    if (sr >= sh) sr = sh - 1;
    if (sc >= sw) sc = sw - 1;
    return sr * MAX_WIDTH_DEF + sc;
  endfunction

  function automatic void nearest_pixel(input word_t w, output bit has_res, output pixel_t px);
    int a, gray;
    logic [RGB_W-1:0] p;
    has_res = 1'b0;
    px = '0;
    if (w.mode == MODE_LOAD) begin
      if (load_lands(w.row, w.col)) begin
        a = int'(w.row) * MAX_WIDTH_DEF + int'(w.col);
        frame_copy[a] = {w.red, w.green, w.blue};
        written[a] = 1'b1;
      end
    end else begin
      has_res = 1'b1;
      if (!fetch_in_range(w.row, w.col)) begin
        px.err = 1'b1;
      end else begin
        p = frame_copy[src_index(w.row, w.col)];
        if (gray_on) begin
          gray = (11 * int'(p[7:0]) + 59 * int'(p[15:8]) + 30 * int'(p[23:16])) / 100;
          px.blue  = PIX_W'(gray);
          px.green = PIX_W'(gray);
          px.red   = PIX_W'(gray);
        end else begin
          px.blue  = p[7:0];
          px.green = p[15:8];
          px.red   = p[23:16];
        end
      end
    end
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= SHOW_ERRORS) $display("%s", msg);
  endfunction

  function automatic void add_load(int row, int col, int b, int g, int r);
    dir_row_t d;
    d = '0;
    d.kind = ROW_WORD;
    d.w = '{MODE_LOAD, COORD_W'(row), COORD_W'(col), PIX_W'(b), PIX_W'(g), PIX_W'(r)};
    dir_rows.push_back(d);
  endfunction

  function automatic void add_fetch(int row, int col, int b, int g, int r, bit e);
    dir_row_t d;
    d = '0;
    d.kind = ROW_WORD;
    d.w = '{MODE_FETCH, COORD_W'(row), COORD_W'(col), '0, '0, '0};
    d.want = '{PIX_W'(b), PIX_W'(g), PIX_W'(r), e};
    dir_rows.push_back(d);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, int data);
    dir_row_t d;
    d = '0;
    d.kind = ROW_CFG;
    d.idx = idx;
    d.data = CFG_W'(data);
    dir_rows.push_back(d);
  endfunction

  // sender bursts: gap taken before driving so start never toggles within one step
  task automatic send_word(input word_t w, input bit typed, input pixel_t want);
    bit has_res;
    pixel_t px;
    if (burst_left == 0) begin
      start  <= 1'b0;
      cfg_we <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
    end
    burst_left--;
    start       <= 1'b1;
    cfg_we      <= 1'b0;
    in_mode     <= w.mode;
    in_row      <= w.row;
    in_col      <= w.col;
    in_blue_in  <= w.blue;
    in_green_in <= w.green;
    in_red_in   <= w.red;
    do @(posedge clk); while (busy);
    nearest_pixel(w, has_res, px);
    if (has_res) pixel_q.push_back(typed ? want : px);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_SRC_WIDTH:  src_w = data;
      CFG_SRC_HEIGHT: src_h = data;
      CFG_OUT_WIDTH:  out_w = data;
      CFG_OUT_HEIGHT: out_h = data;
      CFG_GRAY_EN:    gray_on = data[0];
      default: ;
    endcase
  endtask

  // wait for every pending pixel, then let dropped loads clear the pipe
  task automatic settle();
    start  <= 1'b0;
    cfg_we <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return CFG_W'(1);
      1: return CFG_W'(256);
      2: return CFG_W'(0);
      3: return CFG_W'($urandom_range(257, 511));
      default: return CFG_W'($urandom_range(1, 256));
    endcase
  endfunction

  always @(posedge clk) begin : check_out
    pixel_t want;
    if (rst_n && out_valid) begin
      if (pixel_q.size() == 0) begin
        note_error($sformatf("unexpected word: b=%h g=%h r=%h err=%b",
                             out_blue_out, out_green_out, out_red_out, out_range_error));
      end else begin
        want = pixel_q.pop_front();
        if (out_blue_out !== want.blue || out_green_out !== want.green ||
            out_red_out !== want.red || out_range_error !== want.err) begin
          note_error($sformatf("mismatch: exp b=%h g=%h r=%h err=%b, got b=%h g=%h r=%h err=%b",
                               want.blue, want.green, want.red, want.err,
                               out_blue_out, out_green_out, out_red_out, out_range_error));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    word_t  w;
    word_t  ld;
    int     counted, phase_words, phase, a;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_mode     = MODE_LOAD;
    in_row      = '0;
    in_col      = '0;
    in_blue_in  = '0;
    in_green_in = '0;
    in_red_in   = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    src_w   = DIM_RESET;
    src_h   = DIM_RESET;
    out_w   = DIM_RESET;
    out_h   = DIM_RESET;
    gray_on = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) written[i] = 1'b0;

    // corners at reset sizes, then gray, out of range fetches, dropped loads, scaling
    add_load(0, 0, 'h00, 'h00, 'h00);
    add_load(255, 255, 'hff, 'hff, 'hff);
    add_load(0, 255, 'hff, 'h00, 'h80);
    add_load(255, 0, 'h12, 'h34, 'h56);
    add_fetch(0, 0, 'h00, 'h00, 'h00, 1'b0);
    add_fetch(255, 255, 'hff, 'hff, 'hff, 1'b0);
    add_fetch(0, 255, 'hff, 'h00, 'h80, 1'b0);
    add_fetch(255, 0, 'h12, 'h34, 'h56, 1'b0);
    add_cfg(CFG_GRAY_EN, 1);
    add_fetch(255, 255, 'hff, 'hff, 'hff, 1'b0);
    add_fetch(0, 0, 'h00, 'h00, 'h00, 1'b0);
    add_fetch(0, 255, 'h42, 'h42, 'h42, 1'b0);
    add_cfg(CFG_OUT_WIDTH, 16);
    add_cfg(CFG_OUT_HEIGHT, 8);
    add_fetch(8, 0, 'h00, 'h00, 'h00, 1'b1);
    add_fetch(0, 16, 'h00, 'h00, 'h00, 1'b1);
    add_cfg(CFG_SRC_WIDTH, 4);
    add_cfg(CFG_SRC_HEIGHT, 4);
    add_load(4, 0, 'h77, 'h77, 'h77);
    add_load(0, 4, 'h77, 'h77, 'h77);
    add_load(3, 3, 'haa, 'h55, 'h01);
    add_cfg(CFG_GRAY_EN, 0);
    add_fetch(7, 15, 'haa, 'h55, 'h01, 1'b0);
    add_cfg(CFG_IDX_SPARE, 'h1ff);
    add_fetch(7, 15, 'haa, 'h55, 'h01, 1'b0);
    add_cfg(CFG_OUT_WIDTH, 0);
    add_fetch(0, 0, 'h00, 'h00, 'h00, 1'b1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_word(dir_rows[i].w, dir_rows[i].w.mode == MODE_FETCH, dir_rows[i].want);
      end
    end

    counted = 0;
    for (phase = 0; counted < WORD_TARGET; phase++) begin
      settle();
      if (phase == 0) begin
        write_reg(CFG_SRC_WIDTH, CFG_W'(1));
        write_reg(CFG_SRC_HEIGHT, CFG_W'(1));
        write_reg(CFG_OUT_WIDTH, CFG_W'(1));
        write_reg(CFG_OUT_HEIGHT, CFG_W'(1));
      end else if (phase == 1) begin
        write_reg(CFG_SRC_WIDTH, CFG_W'(256));
        write_reg(CFG_SRC_HEIGHT, CFG_W'(256));
        write_reg(CFG_OUT_WIDTH, CFG_W'(256));
        write_reg(CFG_OUT_HEIGHT, CFG_W'(256));
      end else begin
        write_reg(CFG_SRC_WIDTH, pick_dim());
        write_reg(CFG_SRC_HEIGHT, pick_dim());
        write_reg(CFG_OUT_WIDTH, pick_dim());
        write_reg(CFG_OUT_HEIGHT, pick_dim());
      end
      write_reg(CFG_GRAY_EN, CFG_W'($urandom_range(0, 511)));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_SPARE, CFG_W'($urandom_range(0, 511)));

      phase_words = 0;
      while (phase_words < WORD_TARGET / N_PHASES && counted < WORD_TARGET) begin
        w.blue  = PIX_W'($urandom);
        w.green = PIX_W'($urandom);
        w.red   = PIX_W'($urandom);
        if ($urandom_range(0, 99) < 45) begin
          w.mode = MODE_LOAD;
          if ($urandom_range(0, 99) < 85 && src_w != '0 && src_h != '0) begin
            w.row = COORD_W'($urandom_range(0, dim_top(src_h)));
            w.col = COORD_W'($urandom_range(0, dim_top(src_w)));
          end else begin
            w.row = COORD_W'($urandom);
            w.col = COORD_W'($urandom);
          end
          if (load_lands(w.row, w.col)) begin
            counted++;
            phase_words++;
          end
        end else begin
          w.mode = MODE_FETCH;
          if ($urandom_range(0, 99) < 85 && out_w != '0 && out_h != '0) begin
            w.row = COORD_W'($urandom_range(0, dim_top(out_h)));
            w.col = COORD_W'($urandom_range(0, dim_top(out_w)));
          end else begin
            w.row = COORD_W'($urandom);
            w.col = COORD_W'($urandom);
          end
          // never read an unwritten entry: load it first, or fall back to the origin
          if (fetch_in_range(w.row, w.col)) begin
            a = src_index(w.row, w.col);
            if (!written[a]) begin
              ld = '{MODE_LOAD, COORD_W'(a / MAX_WIDTH_DEF), COORD_W'(a % MAX_WIDTH_DEF),
                     PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom)};
              if (load_lands(ld.row, ld.col)) begin
                send_word(ld, 1'b0, '0);
                counted++;
                phase_words++;
              end else begin
                w.row = '0;
                w.col = '0;
              end
            end
          end
          counted++;
          phase_words++;
        end
        send_word(w, 1'b0, '0);
      end
    end

    settle();
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
